/* hdl/clwg_pkg.sv */
// clwg_pkg: shared types, request codes, display constants and helper functions
// for the character lcd write generator; no dependencies
package clwg_pkg;

    localparam int NUM_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int COL_W        = 6;
    localparam int FUNC_W       = 3;
    localparam int BCD_DIGITS   = 10;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int STEP_W       = $clog2(NUM_W);
    localparam int INIT_LEN     = 3;
    localparam int INIT_IDX_W   = 2;
    localparam int S_TDATA_W    = 48;
    localparam int QUEUE_DEPTH_DEF = 2;

    // request selector codes
    localparam logic [FUNC_W-1:0] FUNC_CMD    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CURSOR = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_NUMBER = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_INIT   = 3'd4;

    // display command bytes
    localparam logic [BYTE_W-1:0] CMD_FUNCTION_SET = 8'b0011_1000;
    localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON   = 8'b0000_1111;
    localparam logic [BYTE_W-1:0] CMD_CLEAR        = 8'b0000_0001;
    localparam logic [BYTE_W-1:0] ASCII_ZERO       = 8'd48;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_NUMBER,
        KIND_INIT
    } kind_t;

    // one classified request as it waits between front and back
    typedef struct packed {
        kind_t              kind;
        logic               is_data;
        logic [BYTE_W-1:0]  byte_val;
        logic [NUM_W-1:0]   number;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [BYTE_W-1:0] init_byte(input logic [INIT_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            2'd0:    b = CMD_FUNCTION_SET;
            2'd1:    b = CMD_DISPLAY_ON;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

    // add-3 correction on every bcd digit of five or more
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (v[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = v[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

/* hdl/clwg_front.sv */
// clwg_front: accepts requests and classifies them into queue entries
// depends on clwg_pkg
module clwg_front
(
    input  logic                            valid,
    input  logic [clwg_pkg::FUNC_W-1:0]     func,
    input  logic [clwg_pkg::BYTE_W-1:0]     byte_value,
    input  logic                            row,
    input  logic [clwg_pkg::COL_W-1:0]      col,
    input  logic [clwg_pkg::NUM_W-1:0]      number,
    input  logic                            q_full,
    output logic                            ready,
    output logic                            push,
    output clwg_pkg::req_t                  entry
);

    logic keep;

    assign ready = !q_full;

    always_comb
    begin
        keep           = 1'b1;
        entry.kind     = clwg_pkg::KIND_SINGLE;
        entry.is_data  = 1'b0;
        entry.byte_val = byte_value;
        entry.number   = number;
        unique case (func)
            clwg_pkg::FUNC_CMD:
            begin
                entry.kind = clwg_pkg::KIND_SINGLE;
            end
            clwg_pkg::FUNC_DATA:
            begin
                entry.is_data = 1'b1;
            end
            clwg_pkg::FUNC_CURSOR:
            begin
                // 0x80 + col, plus 0x40 on the second line
                entry.byte_val = {1'b1, row, col};
            end
            clwg_pkg::FUNC_NUMBER:
            begin
                entry.kind    = clwg_pkg::KIND_NUMBER;
                entry.is_data = 1'b1;
            end
            clwg_pkg::FUNC_INIT:
            begin
                entry.kind = clwg_pkg::KIND_INIT;
            end
            default:
            begin
                keep = 1'b0;   // unused selectors give no writes
            end
        endcase
    end

    assign push = valid && !q_full && keep;

endmodule

/* hdl/clwg_queue.sv */
// clwg_queue: short fifo of classified requests between front and back
// depends on clwg_pkg
module clwg_queue
#(
    parameter int QUEUE_DEPTH = clwg_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  clwg_pkg::req_t      push_entry,
    input  logic                pop,
    output clwg_pkg::req_t      head,
    output clwg_pkg::q_stat_t   stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    clwg_pkg::req_t   slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/clwg_back.sv */
// clwg_back: carries out queued requests, converts numbers by shift-and-add-3
// and drives the registered write stream; depends on clwg_pkg
module clwg_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  clwg_pkg::req_t                  q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [clwg_pkg::BYTE_W-1:0]     m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            converting
);

    localparam int STEP_W = clwg_pkg::STEP_W;
    localparam int NUM_W  = clwg_pkg::NUM_W;
    localparam int BCD_W  = clwg_pkg::BCD_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CONV   = 4'b0010,
        ST_DIGITS = 4'b0100,
        ST_INIT   = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    logic                           started_reg, started_next;
    logic                           out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]               bin_reg, bin_next;
    logic [BCD_W-1:0]               bcd_reg, bcd_next;
    logic                           out_data_reg, out_data_next;
    logic [clwg_pkg::BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                           out_last_reg, out_last_next;

    logic                           out_ready;
    logic                           load;
    logic [BCD_W-1:0]               bcd_adj;
    logic [3:0]                     top_digit;

    assign out_ready  = !out_valid_reg || m_tready;
    assign bcd_adj    = clwg_pkg::bcd_adjust(bcd_reg);
    assign top_digit  = bcd_reg[BCD_W-1 -: 4];
    assign converting = (state_reg == ST_CONV);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        started_next  = started_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        out_data_next = out_data_reg;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        load          = 1'b0;
        q_pop         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && out_ready)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        clwg_pkg::KIND_SINGLE:
                        begin
                            load          = 1'b1;
                            out_data_next = q_head.is_data;
                            out_byte_next = q_head.byte_val;
                            out_last_next = 1'b1;
                        end
                        clwg_pkg::KIND_NUMBER:
                        begin
                            bin_next   = q_head.number;
                            bcd_next   = '0;
                            step_next  = '0;
                            state_next = ST_CONV;
                        end
                        clwg_pkg::KIND_INIT:
                        begin
                            load          = 1'b1;
                            out_data_next = 1'b0;
                            out_byte_next = clwg_pkg::init_byte('0);
                            out_last_next = 1'b0;
                            step_next     = STEP_W'(1);
                            state_next    = ST_INIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[NUM_W-1]};
                bin_next  = {bin_reg[NUM_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    step_next    = STEP_W'(clwg_pkg::BCD_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (top_digit == 4'd0 && !started_reg && step_reg != '0)
                begin
                    // leading zero, drop it
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    step_next = step_reg - 1'b1;
                end
                else if (out_ready)
                begin
                    load          = 1'b1;
                    out_data_next = 1'b1;
                    out_byte_next = clwg_pkg::ASCII_ZERO + {4'd0, top_digit};
                    out_last_next = (step_reg == '0);
                    if (step_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                        step_next    = step_reg - 1'b1;
                        started_next = 1'b1;
                    end
                end
            end
            ST_INIT:
            begin
                if (out_ready)
                begin
                    load          = 1'b1;
                    out_data_next = 1'b0;
                    out_byte_next = clwg_pkg::init_byte(step_reg[clwg_pkg::INIT_IDX_W-1:0]);
                    out_last_next = (step_reg == STEP_W'(clwg_pkg::INIT_LEN - 1));
                    if (step_reg == STEP_W'(clwg_pkg::INIT_LEN - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        out_data_reg <= out_data_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/char_lcd_write_generator.sv */
// char_lcd_write_generator: top level, front classifier, request queue and back end
// depends on clwg_pkg, clwg_front, clwg_queue, clwg_back
//
// turns one display request into the run of register-select/byte writes a
// character lcd expects. the request selector on s_tuser picks a command byte,
// a data byte, a cursor placement (0x80 + col on line 0, 0xc0 + col on line 1),
// an unsigned 32-bit number printed as ascii decimal digits most significant
// first, or the power-up run 0x38, 0x0f, 0x01; selectors 5 to 7 are accepted
// and produce nothing. each write leaves on the master side with the
// register-select level on m_tuser and m_tlast on the final write of the run.
// a front part classifies requests into a small queue (QUEUE_DEPTH entries) so
// new requests are taken while the back end is still busy. the back end issues
// a single write or the power-up run straight from the queue; a number is taken
// from the queue, converted over its 32 bits by shift-and-add-3 and then printed
// one digit at a time with leading zeros dropped. the output register holds one
// finished write while the back end works on.
module char_lcd_write_generator
#(
    parameter int QUEUE_DEPTH = clwg_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // byte_value[7:0], row[8], col[14:9], number[46:15], zero pad[47]
    input  logic [clwg_pkg::S_TDATA_W-1:0]      s_tdata,
    // func[2:0]
    input  logic [clwg_pkg::FUNC_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bus_byte[7:0]
    output logic [clwg_pkg::BYTE_W-1:0]         m_tdata,
    // is_data[0]
    output logic                                m_tuser,
    // last_write
    output logic                                m_tlast
);

    logic               push;
    logic               pop;
    logic               converting;
    clwg_pkg::req_t     push_entry;
    clwg_pkg::req_t     head;
    clwg_pkg::q_stat_t  q_stat;

    // request fields from the packed slave data
    clwg_front u_front
    (
        .valid      (s_tvalid),
        .func       (s_tuser),
        .byte_value (s_tdata[7:0]),
        .row        (s_tdata[8]),
        .col        (s_tdata[14:9]),
        .number     (s_tdata[46:15]),
        .q_full     (q_stat.full),
        .ready      (s_tready),
        .push       (push),
        .entry      (push_entry)
    );

    clwg_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    // conversion and write sequencing with the registered output stage
    clwg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_stat.empty),
        .q_head     (head),
        .q_pop      (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .converting (converting)
    );

    // queue can never be full and empty at once
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // back end only takes a request that is there
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");

    // a request is queued only when the front end shows ready
    a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> s_tvalid && s_tready)
        else $error("push without an accepted request");

    // no write is issued while the number is still being converted
    a_conv_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        converting |=> !$rose(m_tvalid))
        else $error("write issued during conversion");

endmodule
